/* rtl/dpm_pkg.sv */
// dpm_pkg: shared types, widths and helpers of the delimiter pair matcher
// depends on nothing; used by dpm_walker and the top level under rtl
package dpm_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int SKIP_W      = (IDX_W > 8) ? IDX_W : 8;
  localparam int J_W         = SKIP_W + 2;
  localparam int LEN_W       = 11;

  localparam logic [LEN_W-1:0] UNKNOWN_LEN = {LEN_W{1'b1}};

  typedef struct packed {
    logic             first_of_list;
    logic [7:0]       marker;
    logic [LEN_W-1:0] run_length;
    logic             can_open;
    logic             can_close;
    logic [7:0]       nest_level;
    logic [7:0]       initial_skip;
  } item_t;

  typedef struct packed {
    logic [7:0]        marker;
    logic [LEN_W-1:0]  length;
    logic              opens;
    logic              closes;
    logic [7:0]        level;
    logic [SKIP_W-1:0] skip;
    logic              matched;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [7:0] entry_index;
    logic       matched;
    logic [7:0] opener_index;
    logic [7:0] closer_skip;
    logic       still_opens;
    logic       table_full;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FIN
  } walk_state_e;

  // residue test on a 12-bit two's complement sum: even bits weigh +1, odd bits -1,
  // the sign bit (weight -2048) weighs +1 modulo 3
  function automatic logic is_mult3(logic [LEN_W:0] v);
    logic [3:0] pos;
    logic [3:0] neg;
    pos = 4'(v[LEN_W]);
    neg = '0;
    for (int k = 0; k < LEN_W; k++) begin
      if ((k % 2) == 0) begin
        pos = pos + 4'(v[k]);
      end else begin
        neg = neg + 4'(v[k]);
      end
    end
    return (pos == neg) || (pos == neg + 4'd3) || (pos + 4'd3 == neg) ||
           (pos == neg + 4'd6);
  endfunction

endpackage

/* rtl/dpm_entry_ram.sv */
// dpm_entry_ram: generic single-write, single-read synchronous ram
// one write and one registered read per cycle; no package dependency
module dpm_entry_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 38
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dpm_walker.sv */
// dpm_walker: entry allocation, backward skip-link walk and write-back
// depends on dpm_pkg; drives the entry ram ports
module dpm_walker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  dpm_pkg::item_t                in_item_i,
  output logic                          in_ready_o,
  input  logic                          out_free_i,
  output logic                          res_valid_o,
  output dpm_pkg::res_t                 res_o,
  output logic                          ram_we_o,
  output logic [dpm_pkg::IDX_W-1:0]     ram_waddr_o,
  output logic [dpm_pkg::ENTRY_W-1:0]   ram_wdata_o,
  output logic                          ram_re_o,
  output logic [dpm_pkg::IDX_W-1:0]     ram_raddr_o,
  input  logic [dpm_pkg::ENTRY_W-1:0]   ram_rdata_i
);

  dpm_pkg::walk_state_e state_q, state_d;

  logic [dpm_pkg::CNT_W-1:0]         count_q;
  logic [dpm_pkg::IDX_W-1:0]         idx_q;
  logic [dpm_pkg::IDX_W-1:0]         opener_q;
  logic signed [dpm_pkg::J_W-1:0]    j_q;
  dpm_pkg::entry_t                   cl_q;
  logic                              hit_q;
  logic                              full_q;

  logic [dpm_pkg::CNT_W-1:0]         count_eff;
  logic                              start_full;
  logic signed [dpm_pkg::J_W-1:0]    j0;
  logic                              start_walk;
  dpm_pkg::entry_t                   op;
  dpm_pkg::entry_t                   op_upd;
  logic                              cand;
  logic                              refuse;
  logic                              pair_ok;
  logic [dpm_pkg::LEN_W:0]           len_sum;
  logic signed [dpm_pkg::J_W-1:0]    step_j;
  logic                              step_neg;
  logic [dpm_pkg::SKIP_W-1:0]        closer_dist;
  dpm_pkg::entry_t                   new_entry;

  // decode of the incoming item
  always_comb begin
    count_eff  = in_item_i.first_of_list ? '0 : count_q;
    start_full = (count_eff == dpm_pkg::CNT_W'(dpm_pkg::TABLE_DEPTH));
    j0         = $signed(dpm_pkg::J_W'(count_eff))
               - $signed(dpm_pkg::J_W'(in_item_i.initial_skip))
               - $signed(dpm_pkg::J_W'(1));
    start_walk = in_item_i.can_close && !j0[dpm_pkg::J_W-1];
    new_entry.marker  = in_item_i.marker;
    new_entry.length  = in_item_i.run_length;
    new_entry.opens   = in_item_i.can_open;
    new_entry.closes  = in_item_i.can_close;
    new_entry.level   = in_item_i.nest_level;
    new_entry.skip    = dpm_pkg::SKIP_W'(in_item_i.initial_skip);
    new_entry.matched = 1'b0;
  end

  // candidate test on the entry just read
  always_comb begin
    op      = dpm_pkg::entry_t'(ram_rdata_i);
    cand    = op.opens && !op.matched && (op.marker == cl_q.marker) &&
              (op.level == cl_q.level);
    len_sum = {op.length[dpm_pkg::LEN_W-1], op.length}
            + {cl_q.length[dpm_pkg::LEN_W-1], cl_q.length};
    refuse  = (op.closes || cl_q.opens) && (op.length != dpm_pkg::UNKNOWN_LEN) &&
              (cl_q.length != dpm_pkg::UNKNOWN_LEN) && dpm_pkg::is_mult3(len_sum);
    pair_ok = cand && !refuse;
    step_j  = j_q - $signed(dpm_pkg::J_W'(op.skip)) - $signed(dpm_pkg::J_W'(1));
    step_neg = step_j[dpm_pkg::J_W-1];
    op_upd         = op;
    op_upd.matched = 1'b1;
    op_upd.skip    = '0;
    closer_dist    = dpm_pkg::SKIP_W'(idx_q - j_q[dpm_pkg::IDX_W-1:0]);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dpm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (!start_full && start_walk) begin
            state_d = dpm_pkg::ST_READ;
          end else begin
            state_d = dpm_pkg::ST_FIN;
          end
        end
      end
      dpm_pkg::ST_READ: begin
        state_d = dpm_pkg::ST_CHECK;
      end
      dpm_pkg::ST_CHECK: begin
        if (pair_ok || step_neg) begin
          state_d = dpm_pkg::ST_FIN;
        end
      end
      dpm_pkg::ST_FIN: begin
        if (out_free_i) begin
          state_d = dpm_pkg::ST_IDLE;
        end
      end
      default: state_d = dpm_pkg::ST_IDLE;
    endcase
  end

  // ram controls and result
  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = cl_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = j_q[dpm_pkg::IDX_W-1:0];
    unique case (state_q)
      dpm_pkg::ST_IDLE: begin
      end
      dpm_pkg::ST_READ: begin
        ram_re_o = 1'b1;
      end
      dpm_pkg::ST_CHECK: begin
        if (pair_ok) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = j_q[dpm_pkg::IDX_W-1:0];
          ram_wdata_o = op_upd;
        end else if (!step_neg) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = step_j[dpm_pkg::IDX_W-1:0];
        end
      end
      dpm_pkg::ST_FIN: begin
        ram_we_o = !full_q;
      end
      default: begin
      end
    endcase

    in_ready_o  = (state_q == dpm_pkg::ST_IDLE);
    res_valid_o = (state_q == dpm_pkg::ST_FIN);

    res_o = '0;
    if (full_q) begin
      res_o.table_full = 1'b1;
    end else begin
      res_o.entry_index  = 8'(idx_q);
      res_o.matched      = hit_q;
      res_o.opener_index = 8'(opener_q);
      res_o.closer_skip  = (cl_q.skip > dpm_pkg::SKIP_W'(255)) ? 8'hFF : 8'(cl_q.skip);
      res_o.still_opens  = cl_q.opens;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpm_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == dpm_pkg::ST_IDLE) && in_valid_i) begin
        count_q <= start_full ? count_eff : count_eff + dpm_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == dpm_pkg::ST_IDLE) && in_valid_i) begin
      full_q   <= start_full;
      idx_q    <= count_eff[dpm_pkg::IDX_W-1:0];
      cl_q     <= new_entry;
      j_q      <= j0;
      hit_q    <= 1'b0;
      opener_q <= '0;
    end else if (state_q == dpm_pkg::ST_CHECK) begin
      if (pair_ok) begin
        cl_q.skip  <= closer_dist;
        cl_q.opens <= 1'b0;
        hit_q      <= 1'b1;
        opener_q   <= j_q[dpm_pkg::IDX_W-1:0];
      end else begin
        j_q <= step_j;
      end
    end
  end

endmodule

/* rtl/delimiter_pair_matcher_top.sv */
// delimiter_pair_matcher_top: top level of the delimiter pair matcher
// depends on dpm_pkg, dpm_entry_ram and dpm_walker
//
// usage
//   input channel: one delimiter run per transaction (in_valid_i / in_stall_o),
//   taken at a rising edge with in_valid_i high and in_stall_o low
//   output channel: one result per input transaction (out_valid_o / out_stall_i)
//   items are worked one at a time; the state lives in a 256-entry ram with a
//   registered read
// sequence
//   a run that is not a closer, has no reachable earlier entry, or finds the
//   table full goes from idle straight to the finish state, which holds the
//   result until the output register is free; the next run is taken after that
//   a closer with a reachable earlier entry passes a read state, then a check
//   state, where the walk follows skip links one ram read per cycle until it
//   pairs or runs past the first entry; that loop sets the rate
// reset
//   clears the fill count and the control state; the ram is not cleared, only
//   entries below the fill count are ever read
// back-pressure
//   a finished result sits in the output register; a new run is taken while it
//   waits, and the next result is held inside until the register frees
module delimiter_pair_matcher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        first_of_list_i,
  input  logic [7:0]  marker_i,
  input  logic [10:0] run_length_i,
  input  logic        can_open_i,
  input  logic        can_close_i,
  input  logic [7:0]  nest_level_i,
  input  logic [7:0]  initial_skip_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  entry_index_o,
  output logic        matched_o,
  output logic [7:0]  opener_index_o,
  output logic [7:0]  closer_skip_o,
  output logic        still_opens_o,
  output logic        table_full_o
);

  dpm_pkg::item_t                   item;
  dpm_pkg::res_t                    res;
  dpm_pkg::res_t                    out_q;
  logic                             out_valid_q;
  logic                             out_free;
  logic                             walk_ready;
  logic                             res_valid;

  logic                             ram_we;
  logic [dpm_pkg::IDX_W-1:0]        ram_waddr;
  logic [dpm_pkg::ENTRY_W-1:0]      ram_wdata;
  logic                             ram_re;
  logic [dpm_pkg::IDX_W-1:0]        ram_raddr;
  logic [dpm_pkg::ENTRY_W-1:0]      ram_rdata;

  // gather the input fields of one transaction
  always_comb begin
    item.first_of_list = first_of_list_i;
    item.marker        = marker_i;
    item.run_length    = run_length_i;
    item.can_open      = can_open_i;
    item.can_close     = can_close_i;
    item.nest_level    = nest_level_i;
    item.initial_skip  = initial_skip_i;
  end

  assign in_stall_o = !walk_ready;

  // output register is free when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  dpm_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (item),
    .in_ready_o  (walk_ready),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  dpm_entry_ram #(
    .DEPTH (dpm_pkg::TABLE_DEPTH),
    .WIDTH (dpm_pkg::ENTRY_W)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register: valid under reset, payload loaded with the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign entry_index_o  = out_q.entry_index;
  assign matched_o      = out_q.matched;
  assign opener_index_o = out_q.opener_index;
  assign closer_skip_o  = out_q.closer_skip;
  assign still_opens_o  = out_q.still_opens;
  assign table_full_o   = out_q.table_full;

endmodule

/* dv/delimiter_pair_matcher_top_test.sv */
// testbench for delimiter_pair_matcher_top: directed runs, then random delimiter lists
// depends on dpm_pkg and the matcher rtl; checks against its predictor or typed-in results
`timescale 1ns / 1ps

module delimiter_pair_matcher_top_test;

  typedef dpm_pkg::item_t item_t;
  typedef dpm_pkg::res_t  res_t;
  localparam int          TABLE_DEPTH = dpm_pkg::TABLE_DEPTH;
  localparam logic [10:0] UNKNOWN_LEN = dpm_pkg::UNKNOWN_LEN;

  localparam logic [7:0] STAR  = 8'h2A;
  localparam logic [7:0] UNDER = 8'h5F;
  localparam int RULE_OF_THREE = 3;
  localparam int RANDOM_RUNS   = 1530;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam bit LIT  = 1'b1;
  localparam bit PRED = 1'b0;

  // one row of the directed table: the run, and a typed-in result where it is obvious
  typedef struct {
    item_t run;
    bit    literal;
    res_t  want;
  } row_t;

  // one delimiter as the predictor keeps it
  typedef struct {
    logic [7:0] marker;
    int         len;
    bit         known;
    bit         opens;
    bit         closes;
    logic [7:0] level;
    int         skip;
    bit         paired;
  } delim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        first_of_list_i;
  logic [7:0]  marker_i;
  logic [10:0] run_length_i;
  logic        can_open_i;
  logic        can_close_i;
  logic [7:0]  nest_level_i;
  logic [7:0]  initial_skip_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  entry_index_o;
  logic        matched_o;
  logic [7:0]  opener_index_o;
  logic [7:0]  closer_skip_o;
  logic        still_opens_o;
  logic        table_full_o;

  // predictor state
  delim_t delim_book [TABLE_DEPTH];
  int     book_fill = 0;

  res_t expected_results [$];
  int   mismatch_count = 0;
  int   results_seen = 0;

  // shared between sender and receiver
  bit calm = 1'b0;          // no idling on either side while set, but for an asked hold-off
  bit hold_request = 1'b0;  // asks the receiver for one long hold-off

  delimiter_pair_matcher_top dut (.*);

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor: store the run, walk back by skip links, pair under the rule of three
  // ---------------------------------------------------------------------------
  function automatic res_t pair_delimiter(item_t r);
    res_t res;
    int   idx;
    int   j;
    bit   refuse;
    res = '0;
    if (r.first_of_list) begin
      book_fill = 0;
    end
    // full table: run dropped, only the flag is raised
    if (book_fill >= TABLE_DEPTH) begin
      res.table_full = 1'b1;
      return res;
    end
    idx = book_fill;
    book_fill++;
    delim_book[idx].marker = r.marker;
    delim_book[idx].len    = int'($signed(r.run_length));
    delim_book[idx].known  = (r.run_length != UNKNOWN_LEN);
    delim_book[idx].opens  = r.can_open;
    delim_book[idx].closes = r.can_close;
    delim_book[idx].level  = r.nest_level;
    delim_book[idx].skip   = int'(r.initial_skip);
    delim_book[idx].paired = 1'b0;
    if (r.can_close) begin
      // a skip reaching before the start gives no walk at all
      j = idx - int'(r.initial_skip) - 1;
      while (j >= 0) begin
        if (delim_book[j].opens && !delim_book[j].paired &&
            delim_book[j].marker == r.marker && delim_book[j].level == r.nest_level) begin
          // rule of three, waived where either length is unknown
          refuse = (delim_book[j].closes || delim_book[idx].opens) &&
                   delim_book[j].known && delim_book[idx].known &&
                   ((delim_book[j].len + delim_book[idx].len) % RULE_OF_THREE == 0);
          if (!refuse) begin
            delim_book[idx].skip  = idx - j;
            delim_book[idx].opens = 1'b0;
            delim_book[j].paired  = 1'b1;
            delim_book[j].skip    = 0;
            res.matched      = 1'b1;
            res.opener_index = 8'(j);
            break;
          end
        end
        j -= delim_book[j].skip + 1;
      end
    end
    res.entry_index = 8'(idx);
    res.closer_skip = (delim_book[idx].skip > 255) ? 8'd255 : 8'(delim_book[idx].skip);
    res.still_opens = delim_book[idx].opens;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("error: result %0d: %s", results_seen, msg);
  endtask

  // mostly back to back, often a short gap, now and then a long one
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // a well-formed run from a narrow alphabet so that pairs happen, or pure noise
  function automatic item_t random_run(bit noisy, bit head);
    item_t r;
    int    pick;
    if (noisy) begin
      r.first_of_list = 1'($urandom_range(0, 1));
      r.marker        = 8'($urandom);
      r.run_length    = 11'($urandom);
      r.can_open      = 1'($urandom_range(0, 1));
      r.can_close     = 1'($urandom_range(0, 1));
      r.nest_level    = 8'($urandom);
      r.initial_skip  = 8'($urandom);
      return r;
    end
    r.first_of_list = head;
    pick = $urandom_range(0, 19);
    r.marker = (pick < 12) ? STAR : (pick < 19) ? UNDER : 8'($urandom);
    pick = $urandom_range(0, 19);
    r.run_length = (pick < 15) ? 11'($urandom_range(1, 4)) :
                   (pick < 18) ? UNKNOWN_LEN : 11'($urandom);
    // open only, close only, both, or neither
    pick = $urandom_range(0, 9);
    r.can_open  = (pick < 4) || (pick == 8);
    r.can_close = (pick >= 4) && (pick < 9);
    r.nest_level = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
    pick = $urandom_range(0, 19);
    r.initial_skip = (pick < 16) ? 8'd0 : (pick < 19) ? 8'($urandom_range(1, 3)) :
                     8'($urandom);
    return r;
  endfunction

  // offer one run, wait for the transaction, then note what it should give
  task automatic offer_run(input item_t r, input bit literal, input res_t want);
    int   gap;
    res_t got;
    gap = calm ? 0 : idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    first_of_list_i = r.first_of_list;
    marker_i        = r.marker;
    run_length_i    = r.run_length;
    can_open_i      = r.can_open;
    can_close_i     = r.can_close;
    nest_level_i    = r.nest_level;
    initial_skip_i  = r.initial_skip;
    in_valid_i      = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    got = pair_delimiter(r);
    expected_results.push_back(literal ? want : got);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    row_t  plan [$];
    item_t r;
    int    sent;
    int    list_no;
    int    list_len;
    bit    noisy;

    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    first_of_list_i = 1'b0;
    marker_i        = '0;
    run_length_i    = '0;
    can_open_i      = 1'b0;
    can_close_i     = 1'b0;
    nest_level_i    = '0;
    initial_skip_i  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // plain opener then closer
    plan.push_back(row_t'{item_t'{1'b1, STAR, 11'd1, 1'b1, 1'b0, 8'd0, 8'd0}, LIT,
                          res_t'{8'd0, 1'b0, 8'd0, 8'd0, 1'b1, 1'b0}});
    plan.push_back(row_t'{item_t'{1'b0, STAR, 11'd1, 1'b0, 1'b1, 8'd0, 8'd0}, LIT,
                          res_t'{8'd1, 1'b1, 8'd0, 8'd1, 1'b0, 1'b0}});
    // rule of three refuses 1 + 2 against a both-ways opener, 1 + 1 then pairs
    plan.push_back(row_t'{item_t'{1'b1, STAR, 11'd1, 1'b1, 1'b1, 8'd0, 8'd0}, PRED, '0});
    plan.push_back(row_t'{item_t'{1'b0, STAR, 11'd2, 1'b0, 1'b1, 8'd0, 8'd0}, PRED, '0});
    plan.push_back(row_t'{item_t'{1'b0, STAR, 11'd1, 1'b0, 1'b1, 8'd0, 8'd0}, PRED, '0});
    // unknown length waives the rule
    plan.push_back(row_t'{item_t'{1'b1, UNDER, UNKNOWN_LEN, 1'b1, 1'b1, 8'd0, 8'd0}, PRED, '0});
    plan.push_back(row_t'{item_t'{1'b0, UNDER, 11'd2, 1'b1, 1'b1, 8'd0, 8'd0}, PRED, '0});
    // other negative length (-4) counts as signed: -4 + 1 refused, -4 + 2 pairs
    plan.push_back(row_t'{item_t'{1'b1, STAR, 11'h7FC, 1'b1, 1'b1, 8'd3, 8'd0}, PRED, '0});
    plan.push_back(row_t'{item_t'{1'b0, STAR, 11'd1, 1'b0, 1'b1, 8'd3, 8'd0}, PRED, '0});
    plan.push_back(row_t'{item_t'{1'b0, STAR, 11'd2, 1'b0, 1'b1, 8'd3, 8'd0}, PRED, '0});
    // level and marker must agree
    plan.push_back(row_t'{item_t'{1'b1, STAR, 11'd1, 1'b1, 1'b0, 8'd0, 8'd0}, LIT,
                          res_t'{8'd0, 1'b0, 8'd0, 8'd0, 1'b1, 1'b0}});
    plan.push_back(row_t'{item_t'{1'b0, STAR, 11'd1, 1'b0, 1'b1, 8'd1, 8'd0}, PRED, '0});
    plan.push_back(row_t'{item_t'{1'b0, UNDER, 11'd1, 1'b0, 1'b1, 8'd0, 8'd0}, PRED, '0});
    // skip past the start: no walk; a skip landing on the opener pairs
    plan.push_back(row_t'{item_t'{1'b0, STAR, 11'd1, 1'b0, 1'b1, 8'd0, 8'd255}, LIT,
                          res_t'{8'd3, 1'b0, 8'd0, 8'd255, 1'b0, 1'b0}});
    plan.push_back(row_t'{item_t'{1'b0, STAR, 11'd1, 1'b0, 1'b1, 8'd0, 8'd3}, PRED, '0});
    // field extremes: longest and most negative lengths, top marker and level
    plan.push_back(row_t'{item_t'{1'b1, 8'hFF, 11'd1023, 1'b1, 1'b0, 8'd255, 8'd0}, LIT,
                          res_t'{8'd0, 1'b0, 8'd0, 8'd0, 1'b1, 1'b0}});
    plan.push_back(row_t'{item_t'{1'b0, 8'hFF, 11'h400, 1'b0, 1'b1, 8'd255, 8'd0}, PRED, '0});
    plan.push_back(row_t'{item_t'{1'b0, 8'h00, 11'd0, 1'b1, 1'b1, 8'd0, 8'd255}, LIT,
                          res_t'{8'd2, 1'b0, 8'd0, 8'd255, 1'b1, 1'b0}});
    // an opener already paired is passed over
    plan.push_back(row_t'{item_t'{1'b1, STAR, 11'd1, 1'b1, 1'b0, 8'd0, 8'd0}, LIT,
                          res_t'{8'd0, 1'b0, 8'd0, 8'd0, 1'b1, 1'b0}});
    plan.push_back(row_t'{item_t'{1'b0, STAR, 11'd1, 1'b0, 1'b1, 8'd0, 8'd0}, LIT,
                          res_t'{8'd1, 1'b1, 8'd0, 8'd1, 1'b0, 1'b0}});
    plan.push_back(row_t'{item_t'{1'b0, STAR, 11'd1, 1'b0, 1'b1, 8'd0, 8'd0}, PRED, '0});
    // neither opens nor closes: skip passes straight through
    plan.push_back(row_t'{item_t'{1'b0, UNDER, 11'd3, 1'b0, 1'b0, 8'd7, 8'd5}, LIT,
                          res_t'{8'd3, 1'b0, 8'd0, 8'd5, 1'b0, 1'b0}});

    foreach (plan[i]) begin
      offer_run(plan[i].run, plan[i].literal, plan[i].want);
    end

    // random lists: mostly short well-formed ones, two long enough to fill the table
    sent    = 0;
    list_no = 0;
    while (sent < RANDOM_RUNS) begin
      list_no++;
      calm  = ($urandom_range(0, 4) == 0);
      noisy = ($urandom_range(0, 9) == 0);
      if (list_no == 4 || list_no == 40) begin
        list_len = TABLE_DEPTH + 44;
        noisy    = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        list_len = $urandom_range(25, 60);
      end else begin
        list_len = $urandom_range(1, 24);
      end
      // long receiver hold-off while runs keep coming back to back
      if (list_no == 8) begin
        calm         = 1'b1;
        list_len     = 30;
        hold_request = 1'b1;
      end
      // sender pause until every result is home
      if (list_no == 15) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        while (expected_results.size() != 0) @(posedge clk_i);
      end
      for (int k = 0; k < list_len; k++) begin
        r = random_run(noisy, k == 0);
        offer_run(r, PRED, '0);
        sent++;
      end
    end
    calm = 1'b0;

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("delimiter_pair_matcher_top: match");
    end else begin
      $display("delimiter_pair_matcher_top: mismatch");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall windows, free windows, and one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    int free_left;
    out_stall_i = 1'b0;
    stall_left  = 0;
    free_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i  = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i  = 1'b0;
      end else if (calm) begin
        out_stall_i = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i = 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        out_stall_i = 1'b0;
      end else begin
        stall_left  = idle_len();
        free_left   = $urandom_range(1, 6);
        out_stall_i = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result check: each transaction against the oldest expectation, field by field
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        flag_mismatch("result with no run waiting for it");
      end else begin
        want = expected_results.pop_front();
        if (entry_index_o !== want.entry_index)
          flag_mismatch($sformatf("entry_index %0d, want %0d", entry_index_o,
                                  want.entry_index));
        if (matched_o !== want.matched)
          flag_mismatch($sformatf("matched %0b, want %0b", matched_o, want.matched));
        if (opener_index_o !== want.opener_index)
          flag_mismatch($sformatf("opener_index %0d, want %0d", opener_index_o,
                                  want.opener_index));
        if (closer_skip_o !== want.closer_skip)
          flag_mismatch($sformatf("closer_skip %0d, want %0d", closer_skip_o,
                                  want.closer_skip));
        if (still_opens_o !== want.still_opens)
          flag_mismatch($sformatf("still_opens %0b, want %0b", still_opens_o,
                                  want.still_opens));
        if (table_full_o !== want.table_full)
          flag_mismatch($sformatf("table_full %0b, want %0b", table_full_o,
                                  want.table_full));
      end
    end
  end

  // watchdog: far beyond the slowest correct run
  initial begin : watchdog
    #30_000_000;
    $display("delimiter_pair_matcher_top: mismatch");
    $finish;
  end

endmodule

/* sim.f */
rtl/dpm_pkg.sv
rtl/dpm_entry_ram.sv
rtl/dpm_walker.sv
rtl/delimiter_pair_matcher_top.sv
dv/delimiter_pair_matcher_top_test.sv
